// ===== rtl/core/ntp_seconds_to_calendar_macros.svh =====
// assertion macros shared by the calendar decoder modules
// expects clk and rst in the scope of each use

`ifndef NTP_SECONDS_TO_CALENDAR_MACROS_SVH
`define NTP_SECONDS_TO_CALENDAR_MACROS_SVH

// same-cycle implication, off during reset
`define NTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define NTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ntc_pkg.sv =====
// shared types, constants and table functions of the calendar decoder
// no dependencies
`timescale 1ns / 1ps

package ntc_pkg;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 40;
  localparam int unsigned DAYS_W = 16;

  // divider passes: seconds, minutes, hours
  localparam logic [1:0] PASS_SEC  = 2'd0;
  localparam logic [1:0] PASS_MIN  = 2'd1;
  localparam logic [1:0] PASS_HOUR = 2'd2;

  // reciprocals of the constant divisors, quotient is (x * recip) >> shift,
  // exact for every 32-bit x: shift 37 for 60, shift 36 for 24
  localparam logic [IN_W-1:0] RECIP_60 = 32'h8888_8889;
  localparam logic [IN_W-1:0] RECIP_24 = 32'hAAAA_AAAB;

  localparam logic [6:0] SECS_PER_MIN  = 7'd60;
  localparam logic [6:0] MINS_PER_HOUR = 7'd60;
  localparam logic [6:0] HOURS_PER_DAY = 7'd24;
  localparam logic [8:0] DAYS_COMMON   = 9'd365;
  localparam logic [7:0] YEAR_MAX      = 8'd255;
  localparam logic [3:0] MONTH_JAN     = 4'd0;
  localparam logic [3:0] MONTH_FEB     = 4'd1;
  localparam logic [3:0] MONTH_DEC     = 4'd11;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       div_end;
    logic [1:0] pass;
    logic       year_step;
    logic       month_step;
    logic       publish;
  } ntc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } ntc_stat_t;

  function automatic logic [6:0] divisor(input logic [1:0] pass);
    logic [6:0] d;
    case (pass)
      PASS_SEC:  d = SECS_PER_MIN;
      PASS_MIN:  d = MINS_PER_HOUR;
      default:   d = HOURS_PER_DAY;
    endcase
    return d;
  endfunction

  function automatic logic [IN_W-1:0] recip(input logic [1:0] pass);
    logic [IN_W-1:0] r;
    case (pass)
      PASS_HOUR: r = RECIP_24;
      default:   r = RECIP_60;
    endcase
    return r;
  endfunction

  // 1900 is the only multiple of four in range that is not leap
  function automatic logic is_leap(input logic [7:0] yoff);
    return (yoff[1:0] == 2'b00) && (yoff != 8'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default:   len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/ntp_seconds_to_calendar.sv =====
// Converts a 32-bit count of seconds since 1900-01-01 00:00 UTC into second,
// minute, hour, year offset from 1900, month (1-12) and day of month (1-31).
// One word in gives one word out. From acceptance a word passes through three
// divider passes (by 60, 60, 24), each a reciprocal multiply then a remainder
// step, then a year walk that takes off one whole year per step, then a month
// walk that takes off one month per step, and then the result is loaded into
// the output register. A new word is not accepted until the last one has been
// loaded; it is accepted at the earliest in the cycle after that load. The
// input is taken again as soon as the result sits in the output register, even
// if it has not been read yet; an unread result holds the following word back
// before its load.
// Depends on ntc_pkg, ntc_ctrl and ntc_dp.
`timescale 1ns / 1ps

module ntp_seconds_to_calendar (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // seconds_since_1900 [31:0]
  input  logic [ntc_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // second [5:0], minute [11:6], hour [16:12], year_offset [24:17],
  // month [28:25], day_of_month [33:29], zero [39:34]
  output logic [ntc_pkg::OUT_W-1:0] m_tdata
);
  import ntc_pkg::*;

  ntc_cmd_t   cmd;
  ntc_stat_t  stat;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [7:0] year_offset;
  logic [3:0] month;
  logic [4:0] day_of_month;

  ntc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .seconds_since_1900 (s_tdata),
    .cmd                (cmd),
    .stat               (stat),
    .out_second         (second),
    .out_minute         (minute),
    .out_hour           (hour),
    .out_year_offset    (year_offset),
    .out_month          (month),
    .out_day_of_month   (day_of_month)
  );

  assign m_tdata = {6'd0, day_of_month, month, year_offset, hour, minute, second};

endmodule

// ===== rtl/core/ntc_ctrl.sv =====
// sequencer of the calendar decoder: divider passes, year walk, month walk
// depends on ntc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ntp_seconds_to_calendar_macros.svh"

module ntc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ntc_pkg::ntc_stat_t stat,
  output ntc_pkg::ntc_cmd_t  cmd
);
  import ntc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIV_END,
    S_YEAR,
    S_MONTH,
    S_PUBLISH
  } state_t;

  state_t     state;
  logic [1:0] pass;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.pass = pass;
    case (state)
      S_IDLE:    cmd.load       = s_tvalid;
      S_DIV:     cmd.div_step   = 1'b1;
      S_DIV_END: cmd.div_end    = 1'b1;
      S_YEAR:    cmd.year_step  = 1'b1;
      S_MONTH:   cmd.month_step = 1'b1;
      S_PUBLISH: cmd.publish    = !m_tvalid || m_tready;
      default:   cmd.load       = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pass     <= PASS_SEC;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_DIV;
            pass  <= PASS_SEC;
          end
        end
        // quotient in S_DIV, remainder in the S_DIV_END state that follows it
        S_DIV: begin
          state <= S_DIV_END;
        end
        S_DIV_END: begin
          if (pass == PASS_HOUR) begin
            state <= S_YEAR;
          end else begin
            state <= S_DIV;
            pass  <= pass + 2'd1;
          end
        end
        S_YEAR: begin
          if (stat.year_done) begin
            state <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (stat.month_done) begin
            state <= S_PUBLISH;
          end
        end
        S_PUBLISH: begin
          if (cmd.publish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NTC_ASSERT_NXT(a_load_starts, s_tvalid && s_tready,
    state == S_DIV && pass == PASS_SEC, "load did not start the first divider pass")
  `NTC_ASSERT_IMP(a_pass_range, 1'b1,
    pass == PASS_SEC || pass == PASS_MIN || pass == PASS_HOUR, "divider pass out of range")
  `NTC_ASSERT_NXT(a_hour_to_year, state == S_DIV_END && pass == PASS_HOUR,
    state == S_YEAR, "year walk did not follow the hour pass")
  `NTC_ASSERT_NXT(a_publish_valid, cmd.publish,
    m_tvalid && state == S_IDLE, "published word not offered")

endmodule

// ===== rtl/core/ntc_dp.sv =====
// datapath of the calendar decoder: reciprocal-multiply constant divider,
// year and month subtractors, result register; depends on ntc_pkg and macros
`timescale 1ns / 1ps
`include "ntp_seconds_to_calendar_macros.svh"

module ntc_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ntc_pkg::IN_W-1:0]   seconds_since_1900,
  input  ntc_pkg::ntc_cmd_t          cmd,
  output ntc_pkg::ntc_stat_t         stat,
  output logic [5:0]                 out_second,
  output logic [5:0]                 out_minute,
  output logic [4:0]                 out_hour,
  output logic [7:0]                 out_year_offset,
  output logic [3:0]                 out_month,
  output logic [4:0]                 out_day_of_month
);
  import ntc_pkg::*;

  logic [IN_W-1:0]   work;
  logic [IN_W-1:0]   quot;
  logic [5:0]        second;
  logic [5:0]        minute;
  logic [4:0]        hour;
  logic [DAYS_W-1:0] days;
  logic [7:0]        year;
  logic [3:0]        mon;

  logic [IN_W-1:0]   rc;
  logic [2*IN_W-1:0] product;
  logic [IN_W-1:0]   quot_next;
  logic [6:0]        dv;
  logic [12:0]       qd_lo;
  logic [5:0]        rem;
  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic              year_fits;
  logic              month_fits;

  // quotient by reciprocal multiply, shift 36 for 24 and 37 for 60
  assign rc        = recip(cmd.pass);
  assign product   = {{IN_W{1'b0}}, work} * {{IN_W{1'b0}}, rc};
  assign quot_next = (cmd.pass == PASS_HOUR) ? {4'd0, product[63:36]}
                                             : {5'd0, product[63:37]};

  // remainder is below 64, so the low six bits of the product are enough
  assign dv    = divisor(cmd.pass);
  assign qd_lo = {7'd0, quot[5:0]} * {6'd0, dv};
  assign rem   = work[5:0] - qd_lo[5:0];

  assign leap       = is_leap(year);
  assign ylen       = DAYS_COMMON + {8'd0, leap};
  assign mlen       = month_len(mon, leap);
  assign year_fits  = (days >= {7'd0, ylen}) && (year != YEAR_MAX);
  assign month_fits = (days >= {11'd0, mlen}) && (mon != MONTH_DEC);

  assign stat.year_done  = !year_fits;
  assign stat.month_done = !month_fits;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= seconds_since_1900;
    end
    if (cmd.div_step) begin
      quot <= quot_next;
    end
    if (cmd.div_end) begin
      work <= quot;
      case (cmd.pass)
        PASS_SEC: second <= rem;
        PASS_MIN: minute <= rem;
        default: begin
          hour <= rem[4:0];
          days <= quot[DAYS_W-1:0];
          year <= '0;
          mon  <= MONTH_JAN;
        end
      endcase
    end
    if (cmd.year_step && year_fits) begin
      days <= days - {7'd0, ylen};
      year <= year + 8'd1;
    end
    if (cmd.month_step && month_fits) begin
      days <= days - {11'd0, mlen};
      mon  <= mon + 4'd1;
    end
    if (cmd.publish) begin
      out_second       <= second;
      out_minute       <= minute;
      out_hour         <= hour;
      out_year_offset  <= year;
      out_month        <= mon + 4'd1;
      out_day_of_month <= days[4:0] + 5'd1;
    end
  end

  `NTC_ASSERT_IMP(a_rem_range, cmd.div_end, rem < 6'd60, "divider remainder out of range")
  `NTC_ASSERT_IMP(a_month_days, cmd.month_step, days < 16'd366,
    "day of year out of range in month walk")
  `NTC_ASSERT_NXT(a_pub_month, cmd.publish, out_month >= 4'd1 && out_month <= 4'd12,
    "published month out of range")

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for ntp_seconds_to_calendar: directed calendar edges,
// then random and boundary-biased second counts with random stalls on both sides
// depends on ntc_pkg and the ntp_seconds_to_calendar rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RANDOM_WORDS = 1425;
  localparam int unsigned DRAIN_CYCLES = 260;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [7:0] yoff;
    logic [3:0] mon;
    logic [4:0] mday;
  } cal_word_t;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  class calendar_scoreboard;
    cal_word_t   dates_due[$];
    int unsigned n_err;
    int unsigned n_checked;

    static function bit leap_year(int unsigned yoff);
      return (yoff % 4 == 0) && (yoff != 0);
    endfunction

    // mon0 is 0 for january
    static function int unsigned month_days(int unsigned mon0, int unsigned yoff);
      case (mon0)
        1:           return leap_year(yoff) ? 29 : 28;
        3, 5, 8, 10: return 30;
        default:     return 31;
      endcase
    endfunction

    function cal_word_t calendar_of(logic [31:0] secs);
      cal_word_t   w;
      int unsigned t, days, yoff, mon0;
      t      = secs;
      w.sec  = 6'(t % 60);
      t      = t / 60;
      w.min  = 6'(t % 60);
      t      = t / 60;
      w.hr   = 5'(t % 24);
      days   = t / 24;
      yoff   = 0;
      while (yoff < 255 && days >= (leap_year(yoff) ? 366 : 365)) begin
        days = days - (leap_year(yoff) ? 366 : 365);
        yoff++;
      end
      mon0 = 0;
      while (mon0 < 11 && days >= month_days(mon0, yoff)) begin
        days = days - month_days(mon0, yoff);
        mon0++;
      end
      w.yoff = 8'(yoff);
      w.mon  = 4'(mon0 + 1);
      w.mday = 5'(days + 1);
      return w;
    endfunction

    function void note_input(logic [31:0] secs);
      dates_due.push_back(calendar_of(secs));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        n_err++;
      end
    endfunction

    function void check_output(logic [ntc_pkg::OUT_W-1:0] data);
      cal_word_t want;
      if (dates_due.size() == 0) begin
        $error("result word %h arrived with nothing expected", data);
        n_err++;
        return;
      end
      want = dates_due.pop_front();
      n_checked++;
      compare_field("second", want.sec, data[5:0]);
      compare_field("minute", want.min, data[11:6]);
      compare_field("hour", want.hr, data[16:12]);
      compare_field("year_offset", want.yoff, data[24:17]);
      compare_field("month", want.mon, data[28:25]);
      compare_field("day_of_month", want.mday, data[33:29]);
      compare_field("pad", 0, data[39:34]);
    endfunction

    function int unsigned pending();
      return dates_due.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [ntc_pkg::IN_W-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [ntc_pkg::OUT_W-1:0] m_tdata;

  calendar_scoreboard sb;
  int unsigned        cycles;
  int unsigned        burst_left;
  int unsigned        n_sent;
  int unsigned        n_uniform;
  int unsigned        n_edge;
  int unsigned        n_drains;

  ntp_seconds_to_calendar i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // seconds since 1900 for a calendar date, mon and mday 1-based; may exceed 32 bits
  function automatic longint date_to_secs(int unsigned yoff, int unsigned mon,
                                          int unsigned mday, int unsigned hh,
                                          int unsigned mm, int unsigned ss);
    longint days;
    days = 0;
    for (int unsigned y = 0; y < yoff; y++)
      days += calendar_scoreboard::leap_year(y) ? 366 : 365;
    for (int unsigned m = 0; m + 1 < mon; m++)
      days += calendar_scoreboard::month_days(m, yoff);
    days += mday - 1;
    return ((days * 24 + hh) * 60 + mm) * 60 + ss;
  endfunction

  task automatic send_word(input logic [31:0] secs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0)
        gap = $urandom_range(20, 300);
      else if ($urandom_range(0, 2) == 0)
        gap = 0;
      else
        gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= secs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(secs);
    n_sent++;
  endtask

  // sender holds off until every expected word has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    n_drains++;
  endtask

  // receiver stall pattern, changes character after each random-length segment
  initial begin
    rx_mode_t    mode;
    int unsigned seg, k;
    m_tready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(16, 400);
      k    = $urandom_range(2, 9);
      for (int unsigned i = 0; i < seg; i++) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= (i % k) == 0;
          default:   m_tready <= (i % 64) >= 40;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_output(m_tdata);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
    $display("ntp_seconds_to_calendar verification failed");
    $finish;
  end

  initial begin
    longint      v;
    int unsigned yoff, mon, mday, sel;
    sb         = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    burst_left = 0;
    n_sent     = 0;
    n_uniform  = 0;
    n_edge     = 0;
    n_drains   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // field extremes and calendar edges
    send_word(32'd0);
    send_word(32'd59);
    send_word(32'd60);
    send_word(32'd3599);
    send_word(32'd86399);
    send_word(32'd86400);
    send_word(32'(date_to_secs(0, 1, 31, 23, 59, 59)));
    send_word(32'(date_to_secs(0, 2, 1, 0, 0, 0)));
    // 1900 is a common year: feb 28 rolls to mar 1
    send_word(32'(date_to_secs(0, 2, 28, 23, 59, 59)));
    send_word(32'(date_to_secs(0, 3, 1, 0, 0, 0)));
    send_word(32'(date_to_secs(0, 12, 31, 23, 59, 59)));
    send_word(32'(date_to_secs(1, 1, 1, 0, 0, 0)));
    send_word(32'(date_to_secs(4, 2, 29, 12, 0, 0)));
    send_word(32'(date_to_secs(4, 3, 1, 0, 0, 0)));
    // 2000 is leap
    send_word(32'(date_to_secs(100, 2, 29, 23, 59, 59)));
    send_word(32'(date_to_secs(100, 12, 31, 23, 59, 59)));
    send_word(32'(date_to_secs(135, 12, 31, 23, 59, 59)));
    send_word(32'(date_to_secs(136, 1, 1, 0, 0, 0)));
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);
    drain();

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 9);
      v   = -1;
      if (sel < 5) begin
        // near a month, year or day boundary
        yoff = $urandom_range(0, 136);
        mon  = $urandom_range(1, 12);
        mday = $urandom_range(0, 1) ? 1 : calendar_scoreboard::month_days(mon - 1, yoff);
        if ($urandom_range(0, 3) == 0)
          mday = $urandom_range(1, calendar_scoreboard::month_days(mon - 1, yoff));
        if ($urandom_range(0, 1))
          v = date_to_secs(yoff, mon, mday, 0, 0, $urandom_range(0, 2)) - $urandom_range(0, 2);
        else
          v = date_to_secs(yoff, mon, mday, 23, 59, 57 + $urandom_range(0, 2))
              + $urandom_range(0, 2);
      end else if (sel == 5) begin
        v = $urandom_range(0, 1) ? longint'($urandom_range(0, 200000))
                                 : 64'hFFFF_FFFF - $urandom_range(0, 200000);
      end
      if (v >= 0 && v <= 64'hFFFF_FFFF) begin
        send_word(32'(v));
        n_edge++;
      end else begin
        send_word($urandom);
        n_uniform++;
      end
      if (n % 400 == 399)
        drain();
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d second counts sent (%0d near calendar edges, %0d uniform), %0d results checked",
             n_sent, n_edge, n_uniform, sb.n_checked);
    $display("%0d full drains, %0d cycles, %0d mismatches", n_drains, cycles, sb.n_err);
    if (sb.n_err == 0 && sb.pending() == 0)
      $display("ntp_seconds_to_calendar verification clean");
    else
      $display("ntp_seconds_to_calendar verification failed");
    $finish;
  end

endmodule
